### sv/kth_largest_min_heap_top_assert.svh
// Assertion macros for the k-th largest block.
// KTHMH_ASSERT checks a property while out of reset; KTHMH_ASSERT_ALWAYS checks it on every edge.
`ifndef KTH_LARGEST_MIN_HEAP_TOP_ASSERT_SVH
`define KTH_LARGEST_MIN_HEAP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define KTHMH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("kthmh assertion failed");
`define KTHMH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("kthmh assertion failed");
`else
`define KTHMH_ASSERT(lbl, clk, rstn, prop)
`define KTHMH_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### sv/kthmh_pkg.sv
`default_nettype none

package kthmh_pkg;

    // Default number of stored values.
    localparam int HEAP_DEPTH_DEF = 16;

    // Field widths.
    localparam int VALUE_W = 32;
    localparam int K_W     = 5;

    // Update command sent to every cell of the chain.
    typedef struct packed {
        logic ins;   // sorted insert of a new value
        logic rep;   // drop the minimum and insert the new value
    } op_t;

endpackage

`default_nettype wire

### sv/kthmh_cell.sv
`default_nettype none

// One cell of the sorted chain. The chain holds the stored values in
// ascending order, cell 0 holding the minimum. On an insert the cells
// above the new value shift up by one; on a replace the cells below the
// new value shift down by one, pushing the old minimum out.
module kthmh_cell (
    input  wire                                    aclk,
    input  wire kthmh_pkg::op_t                    op,
    input  wire logic signed [kthmh_pkg::VALUE_W-1:0] value_in,
    input  wire logic signed [kthmh_pkg::VALUE_W-1:0] left_val,
    input  wire logic signed [kthmh_pkg::VALUE_W-1:0] right_val,
    input  wire                                    left_b,
    input  wire                                    left_l,
    input  wire                                    valid,
    input  wire                                    right_valid,
    output logic signed [kthmh_pkg::VALUE_W-1:0]   val,
    output logic signed [kthmh_pkg::VALUE_W-1:0]   val_next,
    output logic                                   b,
    output logic                                   l
);

    logic signed [kthmh_pkg::VALUE_W-1:0] val_reg;

    // Local compares: keep place on insert, take right neighbor on replace.
    always_comb begin
        b = valid && (val_reg <= value_in);
        l = right_valid && (right_val < value_in);
        if (op.ins) begin
            if (b) begin
                val_next = val_reg;
            end else if (left_b) begin
                val_next = value_in;
            end else begin
                val_next = left_val;
            end
        end else if (op.rep) begin
            if (l) begin
                val_next = right_val;
            end else if (left_l) begin
                val_next = value_in;
            end else begin
                val_next = val_reg;
            end
        end else begin
            val_next = val_reg;
        end
    end

    // Stored value; contents matter only while the cell is valid.
    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

`default_nettype wire

### sv/kth_largest_min_heap_top.sv
// An item marked last has its result registered onto the m_ outputs when it is accepted.
// Throughput: one item per cycle while s_ready is high; all chain cells update together.
// s_ready drops only while a result waits on the output register and m_ready is low.
// Reset (aresetn low, synchronous): fill count cleared, k_select set to 1, no result pending.
// Stored values are not cleared; cells above the fill count are never read.
`default_nettype none

module kth_largest_min_heap_top #(
    parameter int HEAP_DEPTH = kthmh_pkg::HEAP_DEPTH_DEF
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire logic signed [kthmh_pkg::VALUE_W-1:0] s_value,
    input  wire                                    s_first,
    input  wire                                    s_last,
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic signed [kthmh_pkg::VALUE_W-1:0]   m_kth_largest,
    output logic                                   m_too_few,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [kthmh_pkg::K_W-1:0]         cfg_data
);

    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int KW = (CW > kthmh_pkg::K_W) ? CW : kthmh_pkg::K_W;

    logic [kthmh_pkg::K_W-1:0]            k_select_reg;
    logic [CW-1:0]                        fill_reg;
    logic                                 m_valid_reg;
    logic signed [kthmh_pkg::VALUE_W-1:0] m_kth_reg;
    logic                                 m_too_few_reg;

    logic                                 accept;
    logic [KW-1:0]                        k_ext;
    logic [KW-1:0]                        rank;
    logic [CW-1:0]                        fill_eff;
    logic [CW-1:0]                        fill_next;
    logic                                 do_ins;
    logic                                 do_rep;
    logic                                 too_few_next;
    kthmh_pkg::op_t                       op;

    logic signed [kthmh_pkg::VALUE_W-1:0] cell_val  [HEAP_DEPTH];
    logic signed [kthmh_pkg::VALUE_W-1:0] cell_next [HEAP_DEPTH];
    logic [HEAP_DEPTH-1:0]                cell_b;
    logic [HEAP_DEPTH-1:0]                cell_l;
    logic [HEAP_DEPTH-1:0]                cell_valid;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    // Effective rank: zero acts as one, large values saturate to the depth.
    always_comb begin
        k_ext = KW'(k_select_reg);
        if (k_ext == '0) begin
            rank = KW'(1);
        end else if (k_ext > KW'(HEAP_DEPTH)) begin
            rank = KW'(HEAP_DEPTH);
        end else begin
            rank = k_ext;
        end
    end

    // Decide between insert, replacing the minimum, or dropping the value.
    always_comb begin
        fill_eff  = s_first ? '0 : fill_reg;
        do_ins    = KW'(fill_eff) < rank;
        do_rep    = !do_ins && (fill_eff != '0) && (s_value > cell_val[0]);
        op.ins    = accept && do_ins;
        op.rep    = accept && do_rep;
        fill_next = fill_eff + CW'(do_ins);
        too_few_next = KW'(fill_next) < rank;
    end

    // Chain of cells with neighbor links.
    for (genvar i = 0; i < HEAP_DEPTH; i++) begin : g_cell
        logic signed [kthmh_pkg::VALUE_W-1:0] lv;
        logic signed [kthmh_pkg::VALUE_W-1:0] rv;
        logic                                 lb;
        logic                                 ll;
        logic                                 rvld;

        assign cell_valid[i] = CW'(i) < fill_eff;

        if (i == 0) begin : g_left_end
            assign lv = s_value;
            assign lb = 1'b1;
            assign ll = 1'b1;
        end else begin : g_left
            assign lv = cell_val[i-1];
            assign lb = cell_b[i-1];
            assign ll = cell_l[i-1];
        end

        if (i == HEAP_DEPTH - 1) begin : g_right_end
            assign rv   = cell_val[i];
            assign rvld = 1'b0;
        end else begin : g_right
            assign rv   = cell_val[i+1];
            assign rvld = cell_valid[i+1];
        end

        kthmh_cell u_cell (
            .aclk        (aclk),
            .op          (op),
            .value_in    (s_value),
            .left_val    (lv),
            .right_val   (rv),
            .left_b      (lb),
            .left_l      (ll),
            .valid       (cell_valid[i]),
            .right_valid (rvld),
            .val         (cell_val[i]),
            .val_next    (cell_next[i]),
            .b           (cell_b[i]),
            .l           (cell_l[i])
        );
    end

    // Control registers: rank, fill count and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_select_reg <= kthmh_pkg::K_W'(1);
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                k_select_reg <= cfg_data;
            end
            if (accept) begin
                fill_reg <= fill_next;
            end
            if (accept && s_last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, taken from the chain's new minimum, or zero when too few values are held.
    always_ff @(posedge aclk) begin
        if (accept && s_last) begin
            m_too_few_reg <= too_few_next;
            m_kth_reg     <= too_few_next ? '0 : cell_next[0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_kth_largest = m_kth_reg;
    assign m_too_few     = m_too_few_reg;

`include "kth_largest_min_heap_top_assert.svh"

    `KTHMH_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= CW'(HEAP_DEPTH))
    `KTHMH_ASSERT(a_too_few_zero, aclk, aresetn, (m_valid && m_too_few) |-> (m_kth_largest == '0))
    `KTHMH_ASSERT(a_last_result, aclk, aresetn, (accept && s_last) |=> m_valid)
    `KTHMH_ASSERT(a_fill_grows, aclk, aresetn, (accept && !s_first) |=> (fill_reg >= $past(fill_reg)))
    `KTHMH_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid_reg)

endmodule

`default_nettype wire
